// File: src/rfa_pkg.sv
// Shared types, widths and register indexes for the rotating frame acceleration adder.
// No dependencies; every other file imports this package.
package rfa_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int DATA_WIDTH = 32;
	localparam int VEC_W      = 21;
	localparam int TYPE_W     = 16;
	localparam int CFG_W      = 3 * VEC_W;
	localparam int IDX_W      = 3;

	// register indexes on the write port
	localparam logic [IDX_W-1:0] REG_LIN_ACC  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_ANG_ACC  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_ANG_VEL  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_LIN_VEL  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_CENTRE   = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_GRAVITY  = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_SEL_TYPE = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_KEEP_GRV = IDX_W'(7);

	// intermediate saturation widths
	localparam int DIFF_BITS  = DATA_WIDTH + 2;
	localparam int INNER_BITS = DATA_WIDTH + 10;

	// exact difference, kept at least one bit wider than its saturated form
	localparam int DIFF_RAW_W = ((DATA_WIDTH > VEC_W) ? DATA_WIDTH : VEC_W) + 1;
	localparam int DIFF_EXT_W = ((DIFF_RAW_W > DIFF_BITS) ? DIFF_RAW_W : DIFF_BITS) + 1;

	// first cross products (alpha x d, w x d, w x dv)
	localparam int P1_W   = VEC_W + DIFF_BITS;
	localparam int X1_W   = P1_W + 1;
	localparam int EXT1_W = ((X1_W > INNER_BITS + FRAC_BITS) ? X1_W
	                        : INNER_BITS + FRAC_BITS) + 1;
	localparam int IRND_W = EXT1_W - FRAC_BITS;

	// second cross product (w x inner)
	localparam int P2_W = VEC_W + INNER_BITS;
	localparam int X2_W = P2_W + 1;

	// rotational sum t1 + t2 + 2*t3 and its rounding
	localparam int SUM_W = ((X1_W + 1 > X2_W) ? X1_W + 1 : X2_W) + 2;
	localparam int RS_W  = SUM_W + 1;
	localparam int ROT_W = RS_W - FRAC_BITS;

	// acc_in + lin_acc - gravity, then plus rotation
	localparam int BASE_W = ((DATA_WIDTH > VEC_W) ? DATA_WIDTH : VEC_W) + 2;
	localparam int FIN_W  = ((BASE_W > ROT_W) ? BASE_W : ROT_W) + 1;

	// component order of a cross product: r[i] = a[j]*b[k] - a[k]*b[j]
	localparam logic [1:0] AX_J [3] = '{2'd1, 2'd2, 2'd0};
	localparam logic [1:0] AX_K [3] = '{2'd2, 2'd0, 2'd1};

	typedef logic [2:0][VEC_W-1:0]      vec3_t;
	typedef logic [2:0][DATA_WIDTH-1:0] dvec_t;
	typedef logic [2:0][DIFF_BITS-1:0]  diff3_t;
	typedef logic [2:0][BASE_W-1:0]     base3_t;
	typedef logic [2:0][SUM_W-1:0]      sum3_t;

	typedef struct packed {
		vec3_t             lin_acc;
		vec3_t             ang_acc;
		vec3_t             ang_vel;
		vec3_t             lin_vel;
		vec3_t             centre;
		vec3_t             gravity;
		logic [TYPE_W-1:0] sel_type;
		logic              keep_grav;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic match;
		logic rot_en;
		logic last;
	} ctl_t;

endpackage

// File: src/rotating_frame_accel_adder.sv
// Top level of the rotating frame acceleration adder.
// Depends on rfa_pkg, rfa_cfg_regs, rfa_diff_stage, rfa_rot_core, rfa_out_stage.
//
// One particle is taken on every clock edge with start high (busy is always
// low) and its result appears on the result ports with done high after the
// six-stage pipeline (offsets, first products, inner rounding, second
// products, sum, output rounding and saturation), one beat per particle, in
// order. There is no back-pressure:
// each result is shown for one cycle only, so the receiver must take every
// beat. Registers are written through wr_en/wr_index/wr_data and must be
// changed only while no particle is in flight; there is no clearing pass.
module rotating_frame_accel_adder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                wr_en,
	input  logic [rfa_pkg::IDX_W-1:0]           wr_index,
	input  logic [rfa_pkg::CFG_W-1:0]           wr_data,
	input  logic [rfa_pkg::TYPE_W-1:0]          particle_type,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] pos_x,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] pos_y,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] pos_z,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] vel_x,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] vel_y,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] vel_z,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] acc_in_x,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] acc_in_y,
	input  logic signed [rfa_pkg::DATA_WIDTH-1:0] acc_in_z,
	input  logic                                last_particle,
	output logic                                done,
	output logic signed [rfa_pkg::DATA_WIDTH-1:0] acc_out_x,
	output logic signed [rfa_pkg::DATA_WIDTH-1:0] acc_out_y,
	output logic signed [rfa_pkg::DATA_WIDTH-1:0] acc_out_z,
	output logic                                type_matched,
	output logic                                last_out
);
	import rfa_pkg::*;

	cfg_t   cfg;
	ctl_t   ctl_s1, ctl_s5, ctl_s6;
	diff3_t d_s1, dv_s1;
	base3_t base_s1, base_s5;
	sum3_t  sum_s5;
	dvec_t  pos, vel, acc, acc_s6;

	assign busy = 1'b0;
	assign pos  = {pos_z, pos_y, pos_x};
	assign vel  = {vel_z, vel_y, vel_x};
	assign acc  = {acc_in_z, acc_in_y, acc_in_x};

	rfa_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	rfa_diff_stage u_diff (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (start && !busy),
		.particle_type (particle_type),
		.pos           (pos),
		.vel           (vel),
		.acc           (acc),
		.last_particle (last_particle),
		.ctl_s1        (ctl_s1),
		.d_s1          (d_s1),
		.dv_s1         (dv_s1),
		.base_s1       (base_s1)
	);

	rfa_rot_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.ctl_s1  (ctl_s1),
		.d_s1    (d_s1),
		.dv_s1   (dv_s1),
		.base_s1 (base_s1),
		.ctl_s5  (ctl_s5),
		.sum_s5  (sum_s5),
		.base_s5 (base_s5)
	);

	rfa_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s5  (ctl_s5),
		.sum_s5  (sum_s5),
		.base_s5 (base_s5),
		.ctl_s6  (ctl_s6),
		.acc_s6  (acc_s6)
	);

	assign done         = ctl_s6.valid;
	assign acc_out_x    = acc_s6[0];
	assign acc_out_y    = acc_s6[1];
	assign acc_out_z    = acc_s6[2];
	assign type_matched = ctl_s6.match;
	assign last_out     = ctl_s6.last;

endmodule

// File: src/rfa_cfg_regs.sv
// Configuration register file of the rotating frame acceleration adder.
// Depends on rfa_pkg.
module rfa_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [rfa_pkg::IDX_W-1:0]  wr_index,
	input  logic [rfa_pkg::CFG_W-1:0]  wr_data,
	output rfa_pkg::cfg_t              cfg
);
	import rfa_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LIN_ACC:  cfg_q.lin_acc   <= wr_data;
				REG_ANG_ACC:  cfg_q.ang_acc   <= wr_data;
				REG_ANG_VEL:  cfg_q.ang_vel   <= wr_data;
				REG_LIN_VEL:  cfg_q.lin_vel   <= wr_data;
				REG_CENTRE:   cfg_q.centre    <= wr_data;
				REG_GRAVITY:  cfg_q.gravity   <= wr_data;
				REG_SEL_TYPE: cfg_q.sel_type  <= wr_data[TYPE_W-1:0];
				REG_KEEP_GRV: cfg_q.keep_grav <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/rfa_diff_stage.sv
// Stage 1: type match, offsets from the rotation centre, relative velocity,
// and the linear part of the new acceleration. Depends on rfa_pkg.
module rfa_diff_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rfa_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	input  logic [rfa_pkg::TYPE_W-1:0]   particle_type,
	input  rfa_pkg::dvec_t               pos,
	input  rfa_pkg::dvec_t               vel,
	input  rfa_pkg::dvec_t               acc,
	input  logic                         last_particle,
	output rfa_pkg::ctl_t                ctl_s1,
	output rfa_pkg::diff3_t              d_s1,
	output rfa_pkg::diff3_t              dv_s1,
	output rfa_pkg::base3_t              base_s1
);
	import rfa_pkg::*;

	ctl_t   ctl;
	diff3_t d, dv;
	base3_t base;

	logic signed [DIFF_EXT_W-1:0] dr, vr;
	logic signed [BASE_W-1:0]     lin_term;

	always_comb begin
		ctl.valid  = in_valid;
		ctl.match  = (particle_type == cfg.sel_type);
		ctl.rot_en = ctl.match && (|cfg.ang_acc);
		ctl.last   = last_particle;
		dr = '0;
		vr = '0;
		lin_term = '0;
		for (int i = 0; i < 3; i++) begin
			dr = DIFF_EXT_W'($signed(pos[i])) - DIFF_EXT_W'($signed(cfg.centre[i]));
			vr = DIFF_EXT_W'($signed(vel[i])) - DIFF_EXT_W'($signed(cfg.lin_vel[i]));
			// saturate to DIFF_BITS: upper bits must all match the sign
			if (!dr[DIFF_EXT_W-1] && (|dr[DIFF_EXT_W-2:DIFF_BITS-1]))
				d[i] = {1'b0, {(DIFF_BITS-1){1'b1}}};
			else if (dr[DIFF_EXT_W-1] && !(&dr[DIFF_EXT_W-2:DIFF_BITS-1]))
				d[i] = {1'b1, {(DIFF_BITS-1){1'b0}}};
			else
				d[i] = dr[DIFF_BITS-1:0];
			if (!vr[DIFF_EXT_W-1] && (|vr[DIFF_EXT_W-2:DIFF_BITS-1]))
				dv[i] = {1'b0, {(DIFF_BITS-1){1'b1}}};
			else if (vr[DIFF_EXT_W-1] && !(&vr[DIFF_EXT_W-2:DIFF_BITS-1]))
				dv[i] = {1'b1, {(DIFF_BITS-1){1'b0}}};
			else
				dv[i] = vr[DIFF_BITS-1:0];
			lin_term = '0;
			if (ctl.match) begin
				lin_term = BASE_W'($signed(cfg.lin_acc[i]));
				if (!cfg.keep_grav)
					lin_term = lin_term - BASE_W'($signed(cfg.gravity[i]));
			end
			base[i] = BASE_W'($signed(acc[i])) + lin_term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		d_s1    <= d;
		dv_s1   <= dv;
		base_s1 <= base;
	end

endmodule

// File: src/rfa_rot_core.sv
// Stages 2 to 5: the three cross products, the nested w x (w x d) and the
// exact rotational sum. Depends on rfa_pkg.
module rfa_rot_core (
	input  logic               clk,
	input  logic               arst_n,
	input  rfa_pkg::cfg_t      cfg,
	input  rfa_pkg::ctl_t      ctl_s1,
	input  rfa_pkg::diff3_t    d_s1,
	input  rfa_pkg::diff3_t    dv_s1,
	input  rfa_pkg::base3_t    base_s1,
	output rfa_pkg::ctl_t      ctl_s5,
	output rfa_pkg::sum3_t     sum_s5,
	output rfa_pkg::base3_t    base_s5
);
	import rfa_pkg::*;

	ctl_t   ctl_s2, ctl_s3, ctl_s4;
	base3_t base_s2, base_s3, base_s4;

	// stage 2: first-level products
	logic signed [P1_W-1:0] ad1_s2 [3], ad2_s2 [3];
	logic signed [P1_W-1:0] wd1_s2 [3], wd2_s2 [3];
	logic signed [P1_W-1:0] wv1_s2 [3], wv2_s2 [3];

	// stage 3: cross differences, inner vector rounded and saturated
	logic signed [X1_W-1:0]       t1_s3 [3], t3_s3 [3];
	logic signed [INNER_BITS-1:0] inner_s3 [3];
	logic signed [X1_W-1:0]       t1_c [3], t3_c [3];
	logic signed [INNER_BITS-1:0] inner_c [3];
	logic signed [EXT1_W-1:0]     wd_ext;
	logic signed [IRND_W-1:0]     wd_rnd;

	// stage 4: second-level products
	logic signed [P2_W-1:0] wi1_s4 [3], wi2_s4 [3];
	logic signed [X1_W-1:0] t1_s4 [3], t3_s4 [3];

	// stage 5 sum
	sum3_t                  sum_c;
	logic signed [X2_W-1:0] t2_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		base_s2 <= base_s1;
		base_s3 <= base_s2;
		base_s4 <= base_s3;
		base_s5 <= base_s4;
		for (int i = 0; i < 3; i++) begin
			ad1_s2[i] <= $signed(cfg.ang_acc[AX_J[i]]) * $signed(d_s1[AX_K[i]]);
			ad2_s2[i] <= $signed(cfg.ang_acc[AX_K[i]]) * $signed(d_s1[AX_J[i]]);
			wd1_s2[i] <= $signed(cfg.ang_vel[AX_J[i]]) * $signed(d_s1[AX_K[i]]);
			wd2_s2[i] <= $signed(cfg.ang_vel[AX_K[i]]) * $signed(d_s1[AX_J[i]]);
			wv1_s2[i] <= $signed(cfg.ang_vel[AX_J[i]]) * $signed(dv_s1[AX_K[i]]);
			wv2_s2[i] <= $signed(cfg.ang_vel[AX_K[i]]) * $signed(dv_s1[AX_J[i]]);
			t1_s3[i]    <= t1_c[i];
			t3_s3[i]    <= t3_c[i];
			inner_s3[i] <= inner_c[i];
			wi1_s4[i] <= $signed(cfg.ang_vel[AX_J[i]]) * inner_s3[AX_K[i]];
			wi2_s4[i] <= $signed(cfg.ang_vel[AX_K[i]]) * inner_s3[AX_J[i]];
			t1_s4[i]  <= t1_s3[i];
			t3_s4[i]  <= t3_s3[i];
		end
		sum_s5 <= sum_c;
	end

	always_comb begin
		wd_ext = '0;
		wd_rnd = '0;
		for (int i = 0; i < 3; i++) begin
			t1_c[i] = X1_W'(ad1_s2[i]) - X1_W'(ad2_s2[i]);
			t3_c[i] = X1_W'(wv1_s2[i]) - X1_W'(wv2_s2[i]);
			// round half up: add half an LSB, then floor
			wd_ext = EXT1_W'(wd1_s2[i]) - EXT1_W'(wd2_s2[i])
			       + EXT1_W'(1 << (FRAC_BITS - 1));
			wd_rnd = wd_ext[EXT1_W-1:FRAC_BITS];
			if (!wd_rnd[IRND_W-1] && (|wd_rnd[IRND_W-2:INNER_BITS-1]))
				inner_c[i] = {1'b0, {(INNER_BITS-1){1'b1}}};
			else if (wd_rnd[IRND_W-1] && !(&wd_rnd[IRND_W-2:INNER_BITS-1]))
				inner_c[i] = {1'b1, {(INNER_BITS-1){1'b0}}};
			else
				inner_c[i] = wd_rnd[INNER_BITS-1:0];
		end
	end

	always_comb begin
		t2_c = '0;
		for (int i = 0; i < 3; i++) begin
			t2_c = X2_W'(wi1_s4[i]) - X2_W'(wi2_s4[i]);
			sum_c[i] = SUM_W'(t1_s4[i]) + SUM_W'(t2_c) + (SUM_W'(t3_s4[i]) <<< 1);
		end
	end

endmodule

// File: src/rfa_out_stage.sv
// Stage 6: rounds the rotational sum, adds it to the linear part when rotation
// is enabled and saturates to the output width. Depends on rfa_pkg.
module rfa_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  rfa_pkg::ctl_t    ctl_s5,
	input  rfa_pkg::sum3_t   sum_s5,
	input  rfa_pkg::base3_t  base_s5,
	output rfa_pkg::ctl_t    ctl_s6,
	output rfa_pkg::dvec_t   acc_s6
);
	import rfa_pkg::*;

	dvec_t                    acc_c;
	logic signed [RS_W-1:0]   rs;
	logic signed [ROT_W-1:0]  rot;
	logic signed [FIN_W-1:0]  fin;

	always_comb begin
		rs  = '0;
		rot = '0;
		fin = '0;
		for (int i = 0; i < 3; i++) begin
			rs  = RS_W'($signed(sum_s5[i])) + RS_W'(1 << (FRAC_BITS - 1));
			rot = rs[RS_W-1:FRAC_BITS];
			fin = FIN_W'($signed(base_s5[i]));
			if (ctl_s5.rot_en)
				fin = fin + FIN_W'(rot);
			if (!fin[FIN_W-1] && (|fin[FIN_W-2:DATA_WIDTH-1]))
				acc_c[i] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
			else if (fin[FIN_W-1] && !(&fin[FIN_W-2:DATA_WIDTH-1]))
				acc_c[i] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
			else
				acc_c[i] = fin[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
		end else begin
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		acc_s6 <= acc_c;
	end

endmodule

// File: test/rotating_frame_accel_adder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotating_frame_accel_adder: streams particles under a range
// of frame settings, predicts each new acceleration and checks every result beat.
// Depends on rfa_pkg and the rotating_frame_accel_adder RTL.
module rotating_frame_accel_adder_test;
	import rfa_pkg::*;

	localparam int LATENCY       = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RAND_SETS     = 6;
	localparam int ITEMS_PER_SET = 155;
	localparam int MAX_REPORTS   = 10;

	localparam logic [CFG_W-1:0] ALL_MAX = {3{{1'b0, {(VEC_W-1){1'b1}}}}};
	localparam logic [CFG_W-1:0] ALL_MIN = {3{{1'b1, {(VEC_W-1){1'b0}}}}};
	localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// wide enough that no intermediate product or sum can wrap
	typedef logic signed [95:0] wide_t;
	typedef wide_t wvec_t [3];

	typedef struct packed {
		logic [TYPE_W-1:0] ptype;
		dvec_t             pos;
		dvec_t             vel;
		dvec_t             acc;
		logic              last;
	} particle_t;

	typedef struct packed {
		dvec_t acc;
		logic  matched;
		logic  last;
	} accel_t;

	function automatic wide_t clamp(wide_t v, int bits);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// add half an LSB, then floor
	function automatic wide_t round_q(wide_t v);
		return (v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic wvec_t unpack3(logic [CFG_W-1:0] r);
		wvec_t u;
		for (int k = 0; k < 3; k++)
			u[k] = $signed(r[k*VEC_W +: VEC_W]);
		return u;
	endfunction

	function automatic wvec_t cross3(wvec_t a, wvec_t b);
		wvec_t r;
		for (int i = 0; i < 3; i++)
			r[i] = a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3];
		return r;
	endfunction

	class accel_scoreboard;
		logic [CFG_W-1:0]  lin_acc, ang_acc, ang_vel, lin_vel, centre, gravity;
		logic [TYPE_W-1:0] sel_type;
		logic              keep_grav;
		accel_t            expected_accels[$];
		int                mismatches, particles, hits, batch_ends;

		function new();
			lin_acc = '0; ang_acc = '0; ang_vel = '0;
			lin_vel = '0; centre = '0; gravity = '0;
			sel_type = '0; keep_grav = 1'b0;
			mismatches = 0; particles = 0; hits = 0; batch_ends = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_LIN_ACC:  lin_acc = data;
				REG_ANG_ACC:  ang_acc = data;
				REG_ANG_VEL:  ang_vel = data;
				REG_LIN_VEL:  lin_vel = data;
				REG_CENTRE:   centre = data;
				REG_GRAVITY:  gravity = data;
				REG_SEL_TYPE: sel_type = data[TYPE_W-1:0];
				REG_KEEP_GRV: keep_grav = data[0];
				default: ;
			endcase
		endfunction

		function void note_particle(particle_t p);
			wvec_t  lin, grav, alpha, w, vl, cen, d, dv, t1, inner, t2, t3, acc;
			accel_t e;
			e.matched = (p.ptype == sel_type);
			e.last = p.last;
			for (int i = 0; i < 3; i++)
				acc[i] = $signed(p.acc[i]);
			if (e.matched) begin
				lin = unpack3(lin_acc);
				grav = unpack3(gravity);
				alpha = unpack3(ang_acc);
				w = unpack3(ang_vel);
				vl = unpack3(lin_vel);
				cen = unpack3(centre);
				for (int i = 0; i < 3; i++) begin
					acc[i] = acc[i] + lin[i];
					if (!keep_grav)
						acc[i] = acc[i] - grav[i];
				end
				// rotational terms only with nonzero alpha, whatever w is
				if (alpha[0] != 0 || alpha[1] != 0 || alpha[2] != 0) begin
					for (int i = 0; i < 3; i++) begin
						d[i] = clamp(wide_t'($signed(p.pos[i])) - cen[i], DIFF_BITS);
						dv[i] = clamp(wide_t'($signed(p.vel[i])) - vl[i], DIFF_BITS);
					end
					t1 = cross3(alpha, d);
					inner = cross3(w, d);
					for (int i = 0; i < 3; i++)
						inner[i] = clamp(round_q(inner[i]), INNER_BITS);
					t2 = cross3(w, inner);
					t3 = cross3(w, dv);
					for (int i = 0; i < 3; i++)
						acc[i] = acc[i] + round_q(t1[i] + t2[i] + 2 * t3[i]);
				end
			end
			for (int i = 0; i < 3; i++)
				e.acc[i] = DATA_WIDTH'(clamp(acc[i], DATA_WIDTH));
			expected_accels = {expected_accels, e};
			particles++;
			if (e.matched) hits++;
			if (e.last) batch_ends++;
		endfunction

		function void flag(string what, accel_t want, accel_t got);
			if (mismatches < MAX_REPORTS)
				$display({"mismatch (%s): expected x=%0d y=%0d z=%0d m=%0b l=%0b, ",
					"got x=%0d y=%0d z=%0d m=%0b l=%0b"},
					what, $signed(want.acc[0]), $signed(want.acc[1]), $signed(want.acc[2]),
					want.matched, want.last, $signed(got.acc[0]), $signed(got.acc[1]),
					$signed(got.acc[2]), got.matched, got.last);
			mismatches++;
		endfunction

		function void check_result(accel_t got);
			accel_t want;
			if (expected_accels.size() == 0) begin
				flag("no particle in flight", '0, got);
			end else begin
				want = expected_accels.pop_front();
				if (got !== want)
					flag("wrong value", want, got);
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_index;
	logic [CFG_W-1:0]             wr_data;
	logic [TYPE_W-1:0]            particle_type;
	logic signed [DATA_WIDTH-1:0] pos_x, pos_y, pos_z;
	logic signed [DATA_WIDTH-1:0] vel_x, vel_y, vel_z;
	logic signed [DATA_WIDTH-1:0] acc_in_x, acc_in_y, acc_in_z;
	logic                         last_particle;
	logic                         done;
	logic signed [DATA_WIDTH-1:0] acc_out_x, acc_out_y, acc_out_z;
	logic                         type_matched;
	logic                         last_out;

	accel_scoreboard sb;
	int              idle_pct;
	int              settings;
	int unsigned     cycles = 0;

	rotating_frame_accel_adder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.particle_type(particle_type),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.acc_in_x(acc_in_x), .acc_in_y(acc_in_y), .acc_in_z(acc_in_z),
		.last_particle(last_particle), .done(done),
		.acc_out_x(acc_out_x), .acc_out_y(acc_out_y), .acc_out_z(acc_out_z),
		.type_matched(type_matched), .last_out(last_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("rotating_frame_accel_adder_test failed");
			$finish;
		end
	end

	// input beat taken
	always @(posedge clk) begin : accept_mon
		particle_t p;
		if (arst_n && start && !busy) begin
			p.ptype = particle_type;
			p.pos = {pos_z, pos_y, pos_x};
			p.vel = {vel_z, vel_y, vel_x};
			p.acc = {acc_in_z, acc_in_y, acc_in_x};
			p.last = last_particle;
			sb.note_particle(p);
		end
	end

	// result beat, present for one cycle only
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({acc_out_z, acc_out_y, acc_out_x, type_matched, last_out});
	end

	function automatic logic [CFG_W-1:0] pack3(int x, int y, int z);
		return {VEC_W'(z), VEC_W'(y), VEC_W'(x)};
	endfunction

	function automatic logic [VEC_W-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(VEC_W-1){1'b1}}};
			1: return {1'b1, {(VEC_W-1){1'b0}}};
			2: return '0;
			3: return VEC_W'(int'($urandom_range(0, 16383)) - 8192);
			default: return VEC_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_vec();
		return {rand_comp(), rand_comp(), rand_comp()};
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return '1;
			4, 5, 6: return DATA_WIDTH'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// mostly the selected type, so the rotating-frame path is busy
	function automatic particle_t rand_particle(logic [TYPE_W-1:0] sel);
		particle_t p;
		p.ptype = ($urandom_range(0, 3) != 0) ? sel : TYPE_W'($urandom);
		for (int i = 0; i < 3; i++) begin
			p.pos[i] = rand_word();
			p.vel[i] = rand_word();
			p.acc[i] = rand_word();
		end
		p.last = ($urandom_range(0, 7) == 0);
		return p;
	endfunction

	function automatic particle_t uniform_particle(logic [TYPE_W-1:0] ptype,
			logic [DATA_WIDTH-1:0] v, logic last);
		particle_t p;
		p.ptype = ptype;
		p.pos = {3{v}};
		p.vel = {3{v}};
		p.acc = {3{v}};
		p.last = last;
		return p;
	endfunction

	task automatic send_particle(particle_t p);
		start <= 1'b1;
		particle_type <= p.ptype;
		pos_x <= p.pos[0];
		pos_y <= p.pos[1];
		pos_z <= p.pos[2];
		vel_x <= p.vel[0];
		vel_y <= p.vel[1];
		vel_z <= p.vel[2];
		acc_in_x <= p.acc[0];
		acc_in_y <= p.acc[1];
		acc_in_z <= p.acc[2];
		last_particle <= p.last;
		do @(posedge clk); while (busy);
	endtask

	// idle cycle by cycle, so about idle_pct of the cycles carry no beat;
	// junk on the payload while start is low must be ignored
	task automatic sender_gap();
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			particle_type <= TYPE_W'($urandom);
			acc_in_x <= $urandom;
			last_particle <= 1'b1;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_accels.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic program_frame(logic [CFG_W-1:0] lin, ang_a, ang_v, vlin, cen, grav,
			logic [CFG_W-1:0] sel_word, keep_word);
		write_reg(REG_LIN_ACC, lin);
		write_reg(REG_ANG_ACC, ang_a);
		write_reg(REG_ANG_VEL, ang_v);
		write_reg(REG_LIN_VEL, vlin);
		write_reg(REG_CENTRE, cen);
		write_reg(REG_GRAVITY, grav);
		write_reg(REG_SEL_TYPE, sel_word);
		write_reg(REG_KEEP_GRV, keep_word);
		wr_en <= 1'b0;
		settings++;
	endtask

	// select and keep words carry random upper bits that must be dropped
	task automatic random_frame(int k);
		logic [CFG_W-1:0] sel_word, keep_word;
		sel_word = CFG_W'({$urandom, $urandom});
		keep_word = CFG_W'({$urandom, $urandom});
		case (k)
			0: begin
				sel_word[TYPE_W-1:0] = '1;
				keep_word[0] = 1'b0;
				program_frame(ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX,
					sel_word, keep_word);
			end
			1: begin
				sel_word[TYPE_W-1:0] = '0;
				keep_word[0] = 1'b1;
				program_frame(ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN,
					sel_word, keep_word);
			end
			2: program_frame(rand_vec(), '0, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
				sel_word, keep_word);
			default: program_frame(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec(),
				rand_vec(), sel_word, keep_word);
		endcase
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		particle_type = '0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		vel_x = '0; vel_y = '0; vel_z = '0;
		acc_in_x = '0; acc_in_y = '0; acc_in_z = '0;
		last_particle = 1'b0;
		idle_pct = 0;
		settings = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all terms active, gravity subtracted
		program_frame(pack3(6144, -8192, 1024), pack3(256, -128, 64), pack3(4096, 2048, -1024),
			pack3(512, 0, -512), pack3(4096, -4096, 8192), pack3(0, 0, -40182),
			CFG_W'(16'h0005), CFG_W'(1'b0));
		send_particle(uniform_particle(16'h0005, '0, 1'b0));
		send_particle(uniform_particle(16'h0005, WORD_MAX, 1'b1));
		send_particle(uniform_particle(16'h0005, WORD_MIN, 1'b0));
		send_particle(uniform_particle(16'h0005, '1, 1'b0));
		send_particle(uniform_particle(16'h0004, WORD_MAX, 1'b0));
		send_particle(uniform_particle(16'h0006, WORD_MIN, 1'b1));
		repeat (5) send_particle(rand_particle(16'h0005));
		drain();

		// directed: zero alpha with nonzero w, gravity kept
		program_frame(pack3(-4096, 0, 4096), '0, pack3(8192, -8192, 4096), pack3(1, 2, 3),
			'0, pack3(100, -100, 40182), CFG_W'(16'hFFFF), CFG_W'(1'b1));
		send_particle(uniform_particle(16'hFFFF, WORD_MAX, 1'b0));
		send_particle(uniform_particle(16'hFFFF, 32'h0001_2345, 1'b1));
		send_particle(uniform_particle(16'h0000, WORD_MAX, 1'b0));
		repeat (2) send_particle(rand_particle(16'hFFFF));
		drain();

		// directed: extreme frame vectors
		program_frame(ALL_MIN, ALL_MAX, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN,
			CFG_W'(16'h0000), CFG_W'(1'b0));
		send_particle(uniform_particle(16'h0000, WORD_MAX, 1'b0));
		send_particle(uniform_particle(16'h0000, WORD_MIN, 1'b1));
		send_particle(uniform_particle(16'h0000, '0, 1'b0));
		send_particle(uniform_particle(16'h0001, WORD_MIN, 1'b0));
		repeat (2) send_particle(rand_particle(16'h0000));
		drain();

		for (int k = 0; k < RAND_SETS; k++) begin
			idle_pct = (k < 2) ? 26 : (k < 4) ? 67 : 0;
			random_frame(k);
			repeat (ITEMS_PER_SET) begin
				send_particle(rand_particle(sb.sel_type));
				sender_gap();
			end
			drain();
		end

		if (sb.expected_accels.size() != 0) begin
			$display("%0d expected results never arrived", sb.expected_accels.size());
			sb.mismatches += sb.expected_accels.size();
		end
		$display("covered %0d particles (%0d of the selected type, %0d batch ends)",
			sb.particles, sb.hits, sb.batch_ends);
		$display("over %0d frame settings; %0d mismatching result beats",
			settings, sb.mismatches);
		if (sb.mismatches == 0)
			$display("rotating_frame_accel_adder_test passed");
		else
			$display("rotating_frame_accel_adder_test failed");
		$finish;
	end

endmodule
